### rtl/hrc_pkg.sv
// shared types and constants for the hsv/rgb converter
package hrc_pkg;

    localparam int FRAC_BITS = 12;
    localparam int W         = 12;
    // six times the widest channel difference
    localparam int DEN_W     = W + 3;

    localparam logic [W:0]   ONE_Q = (W + 1)'(1 << FRAC_BITS);
    localparam logic [W-1:0] MAX_Q = {W{1'b1}};

    localparam logic MODE_TO_HSV = 1'b0;
    localparam logic MODE_TO_RGB = 1'b1;

    localparam logic [2:0] SECTOR_RED_RISE   = 3'd0;
    localparam logic [2:0] SECTOR_GREEN_FULL = 3'd1;
    localparam logic [2:0] SECTOR_BLUE_RISE  = 3'd2;
    localparam logic [2:0] SECTOR_BLUE_FULL  = 3'd3;
    localparam logic [2:0] SECTOR_RED_BACK   = 3'd4;

    typedef struct packed {
        logic         req_type;
        logic [W-1:0] first_value;
        logic [W-1:0] second_value;
        logic [W-1:0] third_value;
    } req_t;

    typedef struct packed {
        logic [W-1:0] out_first;
        logic [W-1:0] out_second;
        logic [W-1:0] out_third;
    } rsp_t;

    // one restoring division lane
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [W-1:0]     quo;
    } div_lane_t;

    // values carried alongside the division lanes
    typedef struct packed {
        logic         mode;
        logic         trivial;
        logic         full;
        logic [W-1:0] v;
        logic [W-1:0] s;
        logic [W-1:0] sr;
        logic [W-1:0] st;
        logic [2:0]   sector;
    } side_t;

    typedef struct packed {
        logic      valid;
        side_t     side;
        div_lane_t sat;
        div_lane_t hue;
    } pipe_t;

endpackage

### rtl/hrc_front.sv
// front stages: channel extremes, hue numerator, sector split and saturation products
module hrc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  hrc_pkg::req_t req,
    output hrc_pkg::pipe_t dout
);
    import hrc_pkg::*;

    logic             a_valid_reg;
    logic             a_mode_reg;
    logic [W-1:0]     a_x_reg, a_y_reg, a_z_reg;
    logic [W-1:0]     a_mx_reg, a_mn_reg;
    logic             a_gmax_reg, a_bmax_reg, a_geb_reg;
    logic [2:0]       a_sector_reg;
    logic [W-1:0]     a_rem_reg;

    logic [W-1:0]     mx_next, mn_next;
    logic [DEN_W-1:0] h6;

    logic [W-1:0]     delta;
    logic [DEN_W-1:0] num, d6;
    logic [2*W-1:0]   sr_prod;
    logic [2*W:0]     st_prod;
    logic [W:0]       rem_inv;
    pipe_t            pipe_next, pipe_reg;

    // channel extremes and hue sector
    always_comb
    begin
        mx_next = req.first_value;
        mn_next = req.first_value;
        if (req.second_value > mx_next) mx_next = req.second_value;
        if (req.third_value > mx_next)  mx_next = req.third_value;
        if (req.second_value < mn_next) mn_next = req.second_value;
        if (req.third_value < mn_next)  mn_next = req.third_value;
        h6 = DEN_W'(req.first_value) * DEN_W'(6);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= in_valid;
            a_mode_reg   <= req.req_type;
            a_x_reg      <= req.first_value;
            a_y_reg      <= req.second_value;
            a_z_reg      <= req.third_value;
            a_mx_reg     <= mx_next;
            a_mn_reg     <= mn_next;
            a_gmax_reg   <= (req.second_value == mx_next);
            a_bmax_reg   <= (req.third_value == mx_next);
            a_geb_reg    <= (req.second_value >= req.third_value);
            a_sector_reg <= h6[DEN_W-1:FRAC_BITS];
            a_rem_reg    <= h6[W-1:0];
        end
    end

    // hue numerator, divisors and the two saturation products
    always_comb
    begin
        delta   = a_mx_reg - a_mn_reg;
        d6      = DEN_W'(delta) * DEN_W'(6);
        rem_inv = ONE_Q - {1'b0, a_rem_reg};
        sr_prod = (2*W)'(a_y_reg) * (2*W)'(a_rem_reg);
        st_prod = (2*W+1)'(a_y_reg) * (2*W+1)'(rem_inv);
        priority if (a_gmax_reg)
            num = DEN_W'(2) * DEN_W'(delta) + DEN_W'(a_z_reg) - DEN_W'(a_x_reg);
        else if (a_bmax_reg)
            num = DEN_W'(4) * DEN_W'(delta) + DEN_W'(a_x_reg) - DEN_W'(a_y_reg);
        else if (a_geb_reg)
            num = DEN_W'(a_y_reg) - DEN_W'(a_z_reg);
        else
            num = d6 + DEN_W'(a_y_reg) - DEN_W'(a_z_reg);

        pipe_next.valid       = a_valid_reg;
        pipe_next.side.mode   = a_mode_reg;
        pipe_next.side.trivial = (a_mode_reg == MODE_TO_RGB) ? (a_y_reg == '0)
                                 : ((a_mx_reg == '0) || (delta == '0));
        pipe_next.side.full   = (a_mn_reg == '0);
        pipe_next.side.v      = (a_mode_reg == MODE_TO_RGB) ? a_z_reg : a_mx_reg;
        pipe_next.side.s      = a_y_reg;
        pipe_next.side.sr     = sr_prod[2*W-1:FRAC_BITS];
        pipe_next.side.st     = st_prod[2*W-1:FRAC_BITS];
        pipe_next.side.sector = a_sector_reg;
        pipe_next.sat.rem     = DEN_W'(delta);
        pipe_next.sat.den     = DEN_W'(a_mx_reg);
        pipe_next.sat.quo     = '0;
        pipe_next.hue.rem     = num;
        pipe_next.hue.den     = d6;
        pipe_next.hue.quo     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg.valid <= 1'b0;
        else if (en)
            pipe_reg <= pipe_next;
    end

    assign dout = pipe_reg;

endmodule

### rtl/hrc_div_stage.sv
// one quotient bit of the saturation and hue divisions
module hrc_div_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  hrc_pkg::pipe_t din,
    output hrc_pkg::pipe_t dout
);
    import hrc_pkg::*;

    pipe_t pipe_next, pipe_reg;

    function automatic div_lane_t div_step(input div_lane_t l);
        logic [DEN_W:0] trial;
        div_lane_t      r;
        trial = {l.rem, 1'b0};
        r     = l;
        if (trial >= {1'b0, l.den})
        begin
            r.rem = DEN_W'(trial - {1'b0, l.den});
            r.quo = {l.quo[W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DEN_W-1:0];
            r.quo = {l.quo[W-2:0], 1'b0};
        end
        return r;
    endfunction

    // shift, compare and subtract on both lanes
    always_comb
    begin
        pipe_next     = din;
        pipe_next.sat = div_step(din.sat);
        pipe_next.hue = div_step(din.hue);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pipe_reg.valid <= 1'b0;
        else if (en)
            pipe_reg <= pipe_next;
    end

    assign dout = pipe_reg;

endmodule

### rtl/hrc_back.sv
// last stage: p, q and t products, sector routing and the output register
module hrc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  hrc_pkg::pipe_t din,
    output logic           rsp_valid,
    output hrc_pkg::rsp_t  rsp
);
    import hrc_pkg::*;

    logic [2*W:0] p_prod, q_prod, t_prod;
    logic [W-1:0] p, q, t, v;
    rsp_t         rsp_next, rsp_reg;
    logic         rsp_valid_reg;

    // brightness scaled by the three complements
    always_comb
    begin
        v      = din.side.v;
        p_prod = (2*W+1)'(v) * (2*W+1)'(ONE_Q - {1'b0, din.side.s});
        q_prod = (2*W+1)'(v) * (2*W+1)'(ONE_Q - {1'b0, din.side.sr});
        t_prod = (2*W+1)'(v) * (2*W+1)'(ONE_Q - {1'b0, din.side.st});
        p      = p_prod[2*W-1:FRAC_BITS];
        q      = q_prod[2*W-1:FRAC_BITS];
        t      = t_prod[2*W-1:FRAC_BITS];
    end

    // pick the result for the direction and sector
    always_comb
    begin
        rsp_next.out_third = v;
        if (din.side.mode == MODE_TO_HSV)
        begin
            if (din.side.trivial)
            begin
                rsp_next.out_first  = '0;
                rsp_next.out_second = '0;
            end
            else
            begin
                rsp_next.out_first  = din.hue.quo;
                rsp_next.out_second = din.side.full ? MAX_Q : din.sat.quo;
            end
        end
        else if (din.side.trivial)
        begin
            rsp_next.out_first  = v;
            rsp_next.out_second = v;
        end
        else
        begin
            unique case (din.side.sector)
                SECTOR_RED_RISE:   rsp_next = '{v, t, p};
                SECTOR_GREEN_FULL: rsp_next = '{q, v, p};
                SECTOR_BLUE_RISE:  rsp_next = '{p, v, t};
                SECTOR_BLUE_FULL:  rsp_next = '{p, q, v};
                SECTOR_RED_BACK:   rsp_next = '{t, p, v};
                default:           rsp_next = '{v, p, q};
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (en)
        begin
            rsp_valid_reg <= din.valid;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### rtl/hsv_rgb_converter.sv
// top level of the hsv/rgb converter
//
//  channel | signals                  | transfer when
//  --------+--------------------------+------------------------
//  req     | req_valid req_stall req  | req_valid && !req_stall
//  rsp     | rsp_valid rsp_stall rsp  | rsp_valid && !rsp_stall
//
// one item per cycle while the result is not stalled; each item passes
// two front stages, twelve division stages (one quotient bit each) and one
// output stage. the restoring dividers set the depth.
// reset clears only the valid bits.
// a stalled result freezes the whole pipeline, and req_stall follows it.
module hsv_rgb_converter (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hrc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hrc_pkg::rsp_t rsp
);
    import hrc_pkg::*;

    logic  en;
    pipe_t chain [0:W];

    // pipeline advance
    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    hrc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (req_valid),
        .req      (req),
        .dout     (chain[0])
    );

    // division stages
    for (genvar i = 0; i < W; i++)
    begin : g_div
        hrc_div_stage u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    hrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .din       (chain[W]),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

### rtl/hrc_checker.sv
// port-level checks for the hsv/rgb converter and their binding
module hrc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input hrc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input hrc_pkg::rsp_t rsp
);
    // request is held back only by a waiting result
    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (rsp_valid && rsp_stall))
        else $error("request stalled without a stalled result");

    // a stalled request holds until its transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_stall) |=> (req_valid && $stable(req)))
        else $error("stalled request changed");

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result changed");

    // nothing comes out during reset
    assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // a free output lets requests flow
    assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> !req_stall)
        else $error("request stalled with an empty output");

endmodule

bind hsv_rgb_converter hrc_checker u_hrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
